/* rtl/dmac_pkg.sv */
package dmac_pkg;

   localparam int FIELD_BITS      = 32;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 9;
   localparam int PERIOD_REG_BITS = 9;
   localparam int PCT_BITS        = 7;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SHORT_PERIOD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_PERIOD  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STOP_PERCENT = 2'd2;

   localparam logic [PERIOD_REG_BITS-1:0] SHORT_PERIOD_RESET = 9'd50;
   localparam logic [PERIOD_REG_BITS-1:0] LONG_PERIOD_RESET  = 9'd200;
   localparam logic [PCT_BITS-1:0]        STOP_PERCENT_RESET = 7'd25;
   localparam logic [PCT_BITS-1:0]        PERCENT_SCALE      = 7'd100;

   typedef enum logic [1:0] {
      REL_EQ    = 2'd0,
      REL_ABOVE = 2'd1,
      REL_BELOW = 2'd2
   } rel_type;

   typedef enum logic [1:0] {
      POS_FLAT  = 2'd0,
      POS_SHORT = 2'd1,
      POS_LONG  = 2'd2
   } pos_type;

   localparam logic [1:0] CROSS_NONE   = 2'd0;
   localparam logic [1:0] CROSS_DEATH  = 2'd1;
   localparam logic [1:0] CROSS_GOLDEN = 2'd2;

   localparam logic [1:0] STOP_NONE  = 2'd0;
   localparam logic [1:0] STOP_SHORT = 2'd1;
   localparam logic [1:0] STOP_LONG  = 2'd2;

   localparam logic [1:0] CLOSE_NONE  = 2'd0;
   localparam logic [1:0] CLOSE_LONG  = 2'd1;
   localparam logic [1:0] CLOSE_SHORT = 2'd2;

   localparam logic [1:0] OPEN_NONE  = 2'd0;
   localparam logic [1:0] OPEN_SHORT = 2'd1;
   localparam logic [1:0] OPEN_LONG  = 2'd2;

   typedef struct packed {
      logic                  ready_res;
      logic [1:0]            crossing;
      logic [1:0]            stop_event;
      logic [1:0]            closed_on_cross;
      logic [1:0]            opened;
      logic [FIELD_BITS-1:0] entry_out;
      logic [FIELD_BITS-1:0] exit_price;
   } result_type;

endpackage

/* rtl/dual_moving_average_crossover.sv */
// Dual simple moving average crossover with stop-loss. Each req beat carries
// one closing price; each price yields exactly one rsp beat with the cross,
// stop-loss and trade outcome. The block takes no new price while the last
// is still in front-end stage f0: the two aged samples leaving the short and
// long windows are read from the single read port of the history RAM, one per
// cycle when not stalled. A result passes stages f0, f1, b, c, d and e; a
// two-entry output buffer lets the pipeline keep taking prices while one
// result waits for rsp_ready. The history RAM needs no clearing after reset.
// Write a period register only while the block is idle; doing so restarts
// the warm-up (sums and sample count cleared, open position kept). Index 3
// on the csr port is ignored; csr_ready is always high.
module dual_moving_average_crossover #(
   parameter int MAX_PERIOD = 256,
   parameter int PRICE_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [dmac_pkg::FIELD_BITS-1:0]      req_close_price,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_ready_res,
   output logic [1:0]                           rsp_crossing,
   output logic [1:0]                           rsp_stop_event,
   output logic [1:0]                           rsp_closed_on_cross,
   output logic [1:0]                           rsp_opened,
   output logic [dmac_pkg::FIELD_BITS-1:0]      rsp_entry_out,
   output logic [dmac_pkg::FIELD_BITS-1:0]      rsp_exit_price,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dmac_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [dmac_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import dmac_pkg::*;

   localparam int AW        = $clog2(MAX_PERIOD);
   localparam int PW        = $clog2(MAX_PERIOD + 1);
   localparam int CNTW      = $clog2(MAX_PERIOD + 2);
   localparam int SW        = PRICE_BITS + AW;
   localparam int PRODW     = SW + PW;
   localparam int CW        = (PRODW > 64) ? 64 : PRODW;
   localparam int LIMW      = PRICE_BITS + PCT_BITS;
   localparam int CNT_LIMIT = MAX_PERIOD + 1;

   function automatic logic [PW-1:0] eff_period(input logic [PERIOD_REG_BITS-1:0] r);
      if (r == '0) begin
         return PW'(1);
      end
      if (32'(r) > MAX_PERIOD) begin
         return PW'(MAX_PERIOD);
      end
      return PW'(r);
   endfunction

   // (wp - p) modulo MAX_PERIOD, p in 1..MAX_PERIOD
   function automatic logic [AW-1:0] ring_index(input logic [AW-1:0] wp,
                                                input logic [PW-1:0] p);
      logic [AW:0] w;
      logic [AW:0] pe;
      w  = {1'b0, wp};
      pe = (AW+1)'(p);
      if (w >= pe) begin
         return AW'(w - pe);
      end
      return AW'(w + (AW+1)'(MAX_PERIOD) - pe);
   endfunction

   // configuration
   logic [PERIOD_REG_BITS-1:0] short_period_ff;
   logic [PERIOD_REG_BITS-1:0] long_period_ff;
   logic [PCT_BITS-1:0]        stop_pct_ff;
   logic                       csr_write;
   logic                       restart;
   logic [PW-1:0]              p1;
   logic [PW-1:0]              p2;
   logic [PW-1:0]              pmax;

   // block state
   logic [AW-1:0]   wp_ff, wp_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0]   short_sum_ff, short_sum_in;
   logic [SW-1:0]   long_sum_ff, long_sum_in;
   rel_type         prev_rel_ff, prev_rel_in;
   pos_type         pos_ff, pos_in;
   logic [PRICE_BITS-1:0] entry_ff, entry_in;

   // pipeline
   logic adv;
   logic accept;

   logic                  f0_valid_ff;
   logic [PRICE_BITS-1:0] f0_price_ff;
   logic [AW-1:0]         f0_wp_ff;
   logic [CNTW-1:0]       f0_cnt_ff;

   logic                  f1_valid_ff;
   logic [PRICE_BITS-1:0] f1_price_ff;
   logic [AW-1:0]         f1_wp_ff;
   logic [CNTW-1:0]       f1_cnt_ff;

   logic                  byp_hit_ff;
   logic [PRICE_BITS-1:0] byp_data_ff;

   logic                  b_valid_ff;
   logic [PRICE_BITS-1:0] b_price_ff;
   logic [AW-1:0]         b_wp_ff;
   logic [CNTW-1:0]       b_cnt_ff;
   logic [PRICE_BITS-1:0] b_old1_ff;
   logic [PRICE_BITS-1:0] b_old2;

   logic                  c_valid_ff;
   logic [PRICE_BITS-1:0] c_price_ff;
   logic                  c_rel_en_ff;
   logic                  c_trade_ff;

   logic                  d_valid_ff;
   logic [PRICE_BITS-1:0] d_price_ff;
   logic                  d_rel_en_ff;
   logic                  d_trade_ff;
   logic [CW-1:0]         d_lhs_ff;
   logic [CW-1:0]         d_rhs_ff;
   rel_type               d_rel;
   logic                  d_up;
   logic                  d_dn;
   logic [PRICE_BITS-1:0] d_diff;

   logic                  e_valid_ff;
   logic [PRICE_BITS-1:0] e_price_ff;
   logic                  e_rel_en_ff;
   logic                  e_trade_ff;
   rel_type               e_rel_ff;
   logic                  e_up_ff;
   logic                  e_dn_ff;
   logic [LIMW-1:0]       e_lim_ff;
   logic [LIMW-1:0]       e_dprod_ff;
   result_type            e_res;
   logic                  e_have_close;

   // history RAM
   logic [AW-1:0]         rd_addr;
   logic [PRICE_BITS-1:0] rd_data;
   logic [PRICE_BITS-1:0] f1_old1;

   result_type rsp_data;

   assign p1   = eff_period(short_period_ff);
   assign p2   = eff_period(long_period_ff);
   assign pmax = (p1 > p2) ? p1 : p2;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign restart   = csr_write &&
                      (csr_index == CSR_SHORT_PERIOD || csr_index == CSR_LONG_PERIOD);

   assign req_ready = adv && !f0_valid_ff;
   assign accept    = req_valid && req_ready;

   assign wp_in  = (wp_ff == AW'(MAX_PERIOD - 1)) ? '0 : wp_ff + AW'(1);
   assign cnt_in = (cnt_ff == CNTW'(CNT_LIMIT)) ? cnt_ff : cnt_ff + CNTW'(1);

   // front end holds one item at a time: read short-window sample, then long
   assign rd_addr = f0_valid_ff ? ring_index(f0_wp_ff, p1) : ring_index(f1_wp_ff, p2);

   dmac_ram #(
      .WIDTH (PRICE_BITS),
      .DEPTH (MAX_PERIOD)
   ) u_history (
      .clock   (clock),
      .wr_en   (adv && b_valid_ff),
      .wr_addr (b_wp_ff),
      .wr_data (b_price_ff),
      .rd_en   (adv),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // short period of one reads the entry the previous price is writing now
   assign f1_old1 = (f1_cnt_ff >= CNTW'(p1)) ? (byp_hit_ff ? byp_data_ff : rd_data) : '0;
   assign b_old2  = (b_cnt_ff >= CNTW'(p2)) ? rd_data : '0;

   assign short_sum_in = short_sum_ff + SW'(b_price_ff) - SW'(b_old1_ff);
   assign long_sum_in  = long_sum_ff + SW'(b_price_ff) - SW'(b_old2);

   // relation and stop-loss operands
   always_comb begin
      if (d_lhs_ff > d_rhs_ff) begin
         d_rel = REL_ABOVE;
      end else if (d_lhs_ff < d_rhs_ff) begin
         d_rel = REL_BELOW;
      end else begin
         d_rel = REL_EQ;
      end
      d_up   = d_price_ff > entry_ff;
      d_dn   = d_price_ff < entry_ff;
      d_diff = d_up ? d_price_ff - entry_ff : entry_ff - d_price_ff;
   end

   // stop-loss first, then cross
   always_comb begin
      e_res        = '0;
      e_have_close = 1'b0;
      pos_in       = pos_ff;
      entry_in     = entry_ff;
      prev_rel_in  = e_rel_en_ff ? e_rel_ff : prev_rel_ff;
      if (e_trade_ff) begin
         e_res.ready_res = 1'b1;
         if (pos_ff == POS_SHORT && e_up_ff && e_dprod_ff >= e_lim_ff) begin
            e_res.stop_event = STOP_SHORT;
         end else if (pos_ff == POS_LONG && e_dn_ff && e_dprod_ff >= e_lim_ff) begin
            e_res.stop_event = STOP_LONG;
         end
         if (e_res.stop_event != STOP_NONE) begin
            e_res.entry_out  = FIELD_BITS'(entry_ff);
            e_res.exit_price = FIELD_BITS'(e_price_ff);
            e_have_close     = 1'b1;
            pos_in           = POS_FLAT;
            entry_in         = '0;
         end
         if (prev_rel_ff == REL_ABOVE && e_rel_ff == REL_BELOW) begin
            e_res.crossing = CROSS_DEATH;
            if (pos_in != POS_SHORT) begin
               if (pos_in == POS_LONG) begin
                  e_res.closed_on_cross = CLOSE_LONG;
                  e_res.entry_out       = FIELD_BITS'(entry_in);
                  e_res.exit_price      = FIELD_BITS'(e_price_ff);
                  e_have_close          = 1'b1;
               end
               pos_in         = POS_SHORT;
               entry_in       = e_price_ff;
               e_res.opened   = OPEN_SHORT;
            end
         end else if (prev_rel_ff == REL_BELOW && e_rel_ff == REL_ABOVE) begin
            e_res.crossing = CROSS_GOLDEN;
            if (pos_in != POS_LONG) begin
               if (pos_in == POS_SHORT) begin
                  e_res.closed_on_cross = CLOSE_SHORT;
                  e_res.entry_out       = FIELD_BITS'(entry_in);
                  e_res.exit_price      = FIELD_BITS'(e_price_ff);
                  e_have_close          = 1'b1;
               end
               pos_in         = POS_LONG;
               entry_in       = e_price_ff;
               e_res.opened   = OPEN_LONG;
            end
         end
         if (!e_have_close && e_res.opened != OPEN_NONE) begin
            e_res.entry_out = FIELD_BITS'(e_price_ff);
         end
      end
   end

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         short_period_ff <= SHORT_PERIOD_RESET;
         long_period_ff  <= LONG_PERIOD_RESET;
         stop_pct_ff     <= STOP_PERCENT_RESET;
         wp_ff           <= '0;
         cnt_ff          <= '0;
         short_sum_ff    <= '0;
         long_sum_ff     <= '0;
         prev_rel_ff     <= REL_EQ;
         pos_ff          <= POS_FLAT;
         entry_ff        <= '0;
         f0_valid_ff     <= 1'b0;
         f1_valid_ff     <= 1'b0;
         b_valid_ff      <= 1'b0;
         c_valid_ff      <= 1'b0;
         d_valid_ff      <= 1'b0;
         e_valid_ff      <= 1'b0;
      end else begin
         if (adv) begin
            f0_valid_ff <= accept;
            f1_valid_ff <= f0_valid_ff;
            b_valid_ff  <= f1_valid_ff;
            c_valid_ff  <= b_valid_ff;
            d_valid_ff  <= c_valid_ff;
            e_valid_ff  <= d_valid_ff;
         end
         if (accept) begin
            wp_ff  <= wp_in;
            cnt_ff <= cnt_in;
         end
         if (adv && b_valid_ff) begin
            short_sum_ff <= short_sum_in;
            long_sum_ff  <= long_sum_in;
         end
         if (adv && e_valid_ff) begin
            prev_rel_ff <= prev_rel_in;
            pos_ff      <= pos_in;
            entry_ff    <= entry_in;
         end
         if (csr_write) begin
            unique case (csr_index)
               CSR_SHORT_PERIOD: short_period_ff <= csr_data[PERIOD_REG_BITS-1:0];
               CSR_LONG_PERIOD:  long_period_ff  <= csr_data[PERIOD_REG_BITS-1:0];
               CSR_STOP_PERCENT: stop_pct_ff     <= csr_data[PCT_BITS-1:0];
               default: ;
            endcase
         end
         if (restart) begin
            short_sum_ff <= '0;
            long_sum_ff  <= '0;
            cnt_ff       <= '0;
            prev_rel_ff  <= REL_EQ;
         end
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (accept) begin
         f0_price_ff <= PRICE_BITS'(req_close_price);
         f0_wp_ff    <= wp_ff;
         f0_cnt_ff   <= cnt_ff;
      end
      if (adv) begin
         byp_hit_ff  <= b_valid_ff && (b_wp_ff == rd_addr);
         byp_data_ff <= b_price_ff;

         f1_price_ff <= f0_price_ff;
         f1_wp_ff    <= f0_wp_ff;
         f1_cnt_ff   <= f0_cnt_ff;

         b_price_ff  <= f1_price_ff;
         b_wp_ff     <= f1_wp_ff;
         b_cnt_ff    <= f1_cnt_ff;
         b_old1_ff   <= f1_old1;

         c_price_ff  <= b_price_ff;
         c_rel_en_ff <= b_cnt_ff >= CNTW'(pmax);
         c_trade_ff  <= b_cnt_ff > CNTW'(pmax);

         d_price_ff  <= c_price_ff;
         d_rel_en_ff <= c_rel_en_ff;
         d_trade_ff  <= c_trade_ff;
         d_lhs_ff    <= CW'(PRODW'(short_sum_ff) * PRODW'(p2));
         d_rhs_ff    <= CW'(PRODW'(long_sum_ff) * PRODW'(p1));

         e_price_ff  <= d_price_ff;
         e_rel_en_ff <= d_rel_en_ff;
         e_trade_ff  <= d_trade_ff;
         e_rel_ff    <= d_rel;
         e_up_ff     <= d_up;
         e_dn_ff     <= d_dn;
         e_lim_ff    <= LIMW'(stop_pct_ff) * LIMW'(entry_ff);
         e_dprod_ff  <= LIMW'(d_diff) * LIMW'(PERCENT_SCALE);
      end
   end

   dmac_skid u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (e_valid_ff),
      .in_ready  (adv),
      .in_data   (e_res),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_ready_res       = rsp_data.ready_res;
   assign rsp_crossing        = rsp_data.crossing;
   assign rsp_stop_event      = rsp_data.stop_event;
   assign rsp_closed_on_cross = rsp_data.closed_on_cross;
   assign rsp_opened          = rsp_data.opened;
   assign rsp_entry_out       = rsp_data.entry_out;
   assign rsp_exit_price      = rsp_data.exit_price;

`ifndef NO_ASSERTIONS
   a_front_single: assert property (@(posedge clock) disable iff (reset)
      !(f0_valid_ff && f1_valid_ff))
      else $error("two prices in the RAM read front end");

   a_item_spacing: assert property (@(posedge clock) disable iff (reset)
      !(b_valid_ff && c_valid_ff) && !(d_valid_ff && e_valid_ff))
      else $error("prices closer than two cycles in the pipeline");

   a_flat_entry: assert property (@(posedge clock) disable iff (reset)
      pos_ff == POS_FLAT |-> entry_ff == '0)
      else $error("flat position with nonzero entry price");

   a_stop_vs_cross_close: assert property (@(posedge clock) disable iff (reset)
      e_valid_ff |-> (e_res.stop_event == STOP_NONE || e_res.closed_on_cross == CLOSE_NONE))
      else $error("position closed twice in one beat");

   a_open_needs_cross: assert property (@(posedge clock) disable iff (reset)
      e_valid_ff |-> (e_res.opened == OPEN_NONE || e_res.crossing != CROSS_NONE))
      else $error("position opened without a cross");
`endif

endmodule

/* rtl/dmac_ram.sv */
module dmac_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/dmac_skid.sv */
module dmac_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  dmac_pkg::result_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output dmac_pkg::result_type out_data
);
   import dmac_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic       spare_valid_ff, spare_valid_in;
   result_type out_data_ff, out_data_in;
   result_type spare_data_ff, spare_data_in;
   logic       push;
   logic       pop;

   assign in_ready = !spare_valid_ff;
   assign push     = in_valid && in_ready;
   assign pop      = out_valid_ff && out_ready;

   always_comb begin
      out_valid_in   = out_valid_ff;
      spare_valid_in = spare_valid_ff;
      out_data_in    = out_data_ff;
      spare_data_in  = spare_data_ff;
      if (pop) begin
         if (spare_valid_ff) begin
            out_data_in    = spare_data_ff;
            spare_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = in_data;
         end
      end else if (!out_valid_ff) begin
         out_valid_in = push;
         out_data_in  = in_data;
      end else if (push) begin
         spare_valid_in = 1'b1;
         spare_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         out_valid_ff   <= out_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff   <= out_data_in;
      spare_data_ff <= spare_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule
